[hw/rtl/assert_macros.svh]
// ---------------------------------------------------------------------------
// Assertion macros
// Short forms for the concurrent checks used in the deframer RTL.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

[hw/rtl/fsdc_pkg.sv]
// ---------------------------------------------------------------------------
// fsdc_pkg
// Shared types, constants and functions of the symbol deframer.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package fsdc_pkg;

    localparam int DEF_MAX_BYTES = 32;
    localparam int DEF_MIN_BYTES = 4;

    localparam int SYMBOL_W   = 22;
    localparam int S_TDATA_W  = 24;
    localparam int M_TDATA_W  = 24;
    localparam int BYTE_W     = 8;
    localparam int IDX_W      = 5;
    localparam int FLAGS_W    = 5;
    localparam int OUT_LIMIT  = 31;
    localparam int DATA_LSB   = 5;
    localparam int PARITY_BIT = 3;
    localparam int JQ_DEPTH   = 2;

    localparam logic OP_SYMBOL = 1'b0;
    localparam logic OP_EOP    = 1'b1;

    localparam logic [SYMBOL_W-1:0] START_MASK = 22'h20_0000;
    localparam logic [SYMBOL_W-1:0] STOP_MASK  = 22'h00_0002;
    localparam logic [SYMBOL_W-1:0] FRAME_MASK = 22'h15_5555;
    localparam logic [BYTE_W-1:0]   CRC_POLY   = 8'hD9;

    localparam logic [FLAGS_W-1:0] ERR_START   = 5'h01;
    localparam logic [FLAGS_W-1:0] ERR_STOP    = 5'h02;
    localparam logic [FLAGS_W-1:0] ERR_FRAMING = 5'h04;
    localparam logic [FLAGS_W-1:0] ERR_PARITY  = 5'h08;
    localparam logic [FLAGS_W-1:0] ERR_CRC     = 5'h10;

    typedef struct packed {
        logic [BYTE_W-1:0]  value;
        logic [FLAGS_W-1:0] flags;
    } fsdc_sym_t;

    typedef struct packed {
        logic               bank;
        logic [IDX_W-1:0]   emit;
        logic [FLAGS_W-1:0] flags;
    } fsdc_job_t;

    function automatic fsdc_sym_t fsdc_decode(input logic [SYMBOL_W-1:0] sym);
        fsdc_sym_t r;
        logic [BYTE_W-1:0] v;
        logic [FLAGS_W-1:0] f;
        f = '0;
        for (int k = 0; k < BYTE_W; k++) begin
            v[BYTE_W-1-k] = sym[DATA_LSB+2*k];
        end
        if ((sym & START_MASK) != '0) begin
            f = f | ERR_START;
        end
        if ((sym & STOP_MASK) != STOP_MASK) begin
            f = f | ERR_STOP;
        end
        if ((sym & FRAME_MASK) != FRAME_MASK) begin
            f = f | ERR_FRAMING;
        end
        if (sym[PARITY_BIT] != (^v)) begin
            f = f | ERR_PARITY;
        end
        r.value = v;
        r.flags = f;
        return r;
    endfunction

    // Reflected CRC-8, one byte, LSB first.
    function automatic logic [BYTE_W-1:0] fsdc_crc_step(input logic [BYTE_W-1:0] crc,
                                                        input logic [BYTE_W-1:0] b);
        logic [BYTE_W-1:0] c;
        logic [BYTE_W-1:0] d;
        c = crc;
        d = b;
        for (int k = 0; k < BYTE_W; k++) begin
            if ((c[0] ^ d[0]) == 1'b1) begin
                c = (c >> 1) ^ CRC_POLY;
            end else begin
                c = c >> 1;
            end
            d = d >> 1;
        end
        return c;
    endfunction

endpackage

`default_nettype wire

[hw/rtl/fsdc_ram.sv]
// ---------------------------------------------------------------------------
// fsdc_ram
// Generic single-write, single-read RAM with a registered, enabled read.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module fsdc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  wire logic                     aclk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

[hw/rtl/fsdc_job_fifo.sv]
// ---------------------------------------------------------------------------
// fsdc_job_fifo
// Short queue of closed frames waiting for readout.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module fsdc_job_fifo (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                push,
    input  wire fsdc_pkg::fsdc_job_t push_job,
    input  wire logic                pop,
    output fsdc_pkg::fsdc_job_t      head,
    output logic                     full,
    output logic                     empty
);
    import fsdc_pkg::*;

    localparam int PW = $clog2(JQ_DEPTH);
    localparam int CW = $clog2(JQ_DEPTH + 1);

    fsdc_job_t       mem_reg [JQ_DEPTH];
    logic [PW-1:0]   wr_ptr_reg;
    logic [PW-1:0]   rd_ptr_reg;
    logic [CW-1:0]   count_reg;
    logic [CW-1:0]   count_next;

    assign full  = (count_reg == CW'(JQ_DEPTH));
    assign empty = (count_reg == '0);
    assign head  = mem_reg[rd_ptr_reg];

    always_comb begin
        count_next = count_reg;
        if (push && !pop) begin
            count_next = count_reg + CW'(1);
        end else if (pop && !push) begin
            count_next = count_reg - CW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + PW'(1);
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + PW'(1);
            end
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_job;
        end
    end

endmodule

`default_nettype wire

[hw/rtl/fsdc_front.sv]
// ---------------------------------------------------------------------------
// fsdc_front
// Accepts symbol and end-of-packet transactions, decodes and stores bytes.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module fsdc_front #(
    parameter int MAX_BYTES = fsdc_pkg::DEF_MAX_BYTES,
    parameter int MIN_BYTES = fsdc_pkg::DEF_MIN_BYTES,
    parameter int ADDR_W    = $clog2(fsdc_pkg::DEF_MAX_BYTES) + 1
) (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire logic                                s_tvalid,
    output logic                                     s_tready,
    input  wire logic [fsdc_pkg::S_TDATA_W-1:0]      s_tdata,
    input  wire logic [0:0]                          s_tuser,
    input  wire logic                                q_full,
    output logic                                     q_push,
    output fsdc_pkg::fsdc_job_t                      q_job,
    output logic                                     wr_en,
    output logic [ADDR_W-1:0]                        wr_addr,
    output logic [fsdc_pkg::BYTE_W-1:0]              wr_data,
    output logic                                     bank
);
    import fsdc_pkg::*;

    localparam int SLOT_W = ADDR_W - 1;
    localparam int CNT_W  = $clog2(MAX_BYTES + 1);
    localparam int EXT_W  = CNT_W + IDX_W + 1;

    logic [CNT_W-1:0]   count_reg;
    logic [FLAGS_W-1:0] err_reg;
    logic [BYTE_W-1:0]  crc_run_reg;
    logic [BYTE_W-1:0]  crc_bl_reg;
    logic [BYTE_W-1:0]  last_byte_reg;
    logic               bank_reg;

    fsdc_sym_t          dec;
    logic [BYTE_W-1:0]  crc_next;
    logic [EXT_W-1:0]   count_ext;
    logic [EXT_W-1:0]   count_m1;
    logic               accept;
    logic               is_eop;
    logic               store_en;

    assign s_tready = !q_full;
    assign accept   = s_tvalid && s_tready;
    assign is_eop   = (s_tuser[0] == OP_EOP);

    always_comb begin
        dec       = fsdc_decode(s_tdata[SYMBOL_W-1:0]);
        crc_next  = fsdc_crc_step(crc_run_reg, dec.value);
        count_ext = EXT_W'(count_reg);
        count_m1  = count_ext - EXT_W'(1);
        store_en  = accept && !is_eop && (count_ext < EXT_W'(MAX_BYTES));
        q_push    = accept && is_eop && (count_ext >= EXT_W'(MIN_BYTES));
        q_job.bank = bank_reg;
        if (count_m1 > EXT_W'(OUT_LIMIT)) begin
            q_job.emit = IDX_W'(OUT_LIMIT);
        end else begin
            q_job.emit = IDX_W'(count_m1);
        end
        q_job.flags = err_reg;
        if (crc_bl_reg != last_byte_reg) begin
            q_job.flags = err_reg | ERR_CRC;
        end
    end

    assign wr_en   = store_en;
    assign wr_addr = {bank_reg, SLOT_W'(count_reg)};
    assign wr_data = dec.value;
    assign bank    = bank_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg   <= '0;
            err_reg     <= '0;
            crc_run_reg <= '0;
            crc_bl_reg  <= '0;
            bank_reg    <= 1'b0;
        end else if (store_en) begin
            count_reg   <= count_reg + CNT_W'(1);
            err_reg     <= err_reg | dec.flags;
            crc_bl_reg  <= crc_run_reg;
            crc_run_reg <= crc_next;
        end else if (accept && is_eop) begin
            count_reg   <= '0;
            err_reg     <= '0;
            crc_run_reg <= '0;
            crc_bl_reg  <= '0;
            if (q_push) begin
                bank_reg <= !bank_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (store_en) begin
            last_byte_reg <= dec.value;
        end
    end

endmodule

`default_nettype wire

[hw/rtl/fsdc_back.sv]
// ---------------------------------------------------------------------------
// fsdc_back
// Reads a closed frame out of the byte store and drives the result stream.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module fsdc_back #(
    parameter int ADDR_W = $clog2(fsdc_pkg::DEF_MAX_BYTES) + 1
) (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            q_empty,
    input  wire fsdc_pkg::fsdc_job_t             q_head,
    output logic                                 q_pop,
    output logic                                 rd_en,
    output logic [ADDR_W-1:0]                    rd_addr,
    input  wire logic [fsdc_pkg::BYTE_W-1:0]     rd_data,
    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    output logic [fsdc_pkg::M_TDATA_W-1:0]       m_tdata,
    output logic                                 m_tlast,
    output logic                                 busy
);
    import fsdc_pkg::*;

    localparam int SLOT_W = ADDR_W - 1;
    localparam int PAD_W  = M_TDATA_W - BYTE_W - IDX_W - FLAGS_W;

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_READ = 1'b1;

    logic               state_reg;
    logic               state_next;
    logic [IDX_W-1:0]   rd_idx_reg;
    logic [IDX_W-1:0]   rd_idx_next;

    logic               p1_valid_reg;
    logic [IDX_W-1:0]   p1_idx_reg;
    logic [FLAGS_W-1:0] p1_flags_reg;
    logic               p1_last_reg;

    logic               out_valid_reg;
    logic [M_TDATA_W-1:0] out_data_reg;
    logic               out_last_reg;

    logic               advance;
    logic               issue;
    logic               last_issue;

    assign advance    = !out_valid_reg || m_tready;
    assign issue      = (state_reg == ST_READ) && advance;
    assign last_issue = (rd_idx_reg == (q_head.emit - IDX_W'(1)));
    assign q_pop      = issue && last_issue;
    assign rd_en      = issue;
    assign rd_addr    = {q_head.bank, SLOT_W'(rd_idx_reg)};
    assign busy       = (state_reg == ST_READ);

    always_comb begin
        state_next  = state_reg;
        rd_idx_next = rd_idx_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (!q_empty) begin
                    state_next  = ST_READ;
                    rd_idx_next = '0;
                end
            end
            ST_READ: begin
                if (issue) begin
                    rd_idx_next = rd_idx_reg + IDX_W'(1);
                    if (last_issue) begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            rd_idx_reg    <= '0;
            p1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg  <= state_next;
            rd_idx_reg <= rd_idx_next;
            if (advance) begin
                p1_valid_reg  <= issue;
                out_valid_reg <= p1_valid_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            p1_idx_reg   <= rd_idx_reg;
            p1_flags_reg <= q_head.flags;
            p1_last_reg  <= last_issue;
            out_data_reg <= {PAD_W'(0), p1_flags_reg, p1_idx_reg, rd_data};
            out_last_reg <= p1_last_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tlast  = out_last_reg;

endmodule

`default_nettype wire

[hw/rtl/frame_symbol_deframer_crc_check_core.sv]
// ---------------------------------------------------------------------------
// frame_symbol_deframer_crc_check_core
// Symbol deframer with reflected CRC-8 check and frame readout.
//
// Channel  | Ports                       | Transaction
// input    | s_tvalid s_tready s_tdata   | symbol word, or end-of-packet when
//          | s_tuser                     | s_tuser[0] is set
// result   | m_tvalid m_tready m_tdata   | one stored byte with index and
//          | m_tlast                     | error flags, tlast on the final byte
//
// The front takes one transaction per cycle while the job queue has room.
// A closed frame is read out at one byte per cycle while m_tready allows,
// via the read state, the store read and the output register. The byte
// store holds two frames; the input stalls only while two closed frames
// await readout. Reset is synchronous; the byte store needs no clearing.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module frame_symbol_deframer_crc_check_core #(
    parameter int MAX_BYTES = fsdc_pkg::DEF_MAX_BYTES,
    parameter int MIN_BYTES = fsdc_pkg::DEF_MIN_BYTES
) (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    input  wire logic                             s_tvalid,
    output logic                                  s_tready,
    // symbol [21:0], zeros above
    input  wire logic [fsdc_pkg::S_TDATA_W-1:0]   s_tdata,
    // opcode [0]
    input  wire logic [0:0]                       s_tuser,
    output logic                                  m_tvalid,
    input  wire logic                             m_tready,
    // byte_value [7:0], byte_index [12:8], frame_errors [17:13], zeros above
    output logic [fsdc_pkg::M_TDATA_W-1:0]        m_tdata,
    output logic                                  m_tlast
);
    import fsdc_pkg::*;

    localparam int ADDR_W = $clog2(MAX_BYTES) + 1;
    localparam int DEPTH  = 2 ** ADDR_W;

    fsdc_job_t           q_job;
    fsdc_job_t           q_head;
    logic                q_push;
    logic                q_pop;
    logic                q_full;
    logic                q_empty;
    logic                wr_en;
    logic [ADDR_W-1:0]   wr_addr;
    logic [BYTE_W-1:0]   wr_data;
    logic                rd_en;
    logic [ADDR_W-1:0]   rd_addr;
    logic [BYTE_W-1:0]   rd_data;
    logic                front_bank;
    logic                back_busy;

    fsdc_front #(
        .MAX_BYTES (MAX_BYTES),
        .MIN_BYTES (MIN_BYTES),
        .ADDR_W    (ADDR_W)
    ) u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_job    (q_job),
        .wr_en    (wr_en),
        .wr_addr  (wr_addr),
        .wr_data  (wr_data),
        .bank     (front_bank)
    );

    fsdc_job_fifo u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (q_push),
        .push_job (q_job),
        .pop      (q_pop),
        .head     (q_head),
        .full     (q_full),
        .empty    (q_empty)
    );

    fsdc_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (DEPTH)
    ) u_store (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    fsdc_back #(
        .ADDR_W (ADDR_W)
    ) u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_empty  (q_empty),
        .q_head   (q_head),
        .q_pop    (q_pop),
        .rd_en    (rd_en),
        .rd_addr  (rd_addr),
        .rd_data  (rd_data),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .busy     (back_busy)
    );

    // The readout must never run on the bank that the front is filling.
    `ASSERT_IMP(a_bank_split, aclk, aresetn, back_busy && !q_full, front_bank != q_head.bank)
    `ASSERT_IMP(a_idle_empty, aclk, aresetn, q_empty, !back_busy)
    `ASSERT_NXT(a_start_read, aclk, aresetn, !q_empty && !back_busy, back_busy)
    // A delivered frame holds at least three bytes, so its final index is two or more.
    `ASSERT_IMP(a_last_index, aclk, aresetn, m_tvalid && m_tlast, m_tdata[12:8] > 5'd1)

endmodule

`default_nettype wire

[tb/sv/testbench.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// testbench
// Checks the symbol deframer with CRC-8 check against an in-bench
// prediction of every frame readout. Frames are driven as symbol words and
// end-of-packet transactions, with random sender gaps and receiver stalls.
// Each byte read out is compared with the oldest predicted byte.
// ---------------------------------------------------------------------------

module testbench;

    import fsdc_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int ITEM_TARGET    = 370;
    localparam int REPORT_LIMIT   = 10;

    typedef struct packed {
        logic [BYTE_W-1:0]  value;
        logic [IDX_W-1:0]   index;
        logic [FLAGS_W-1:0] flags;
        logic               last;
    } frame_byte_t;

    logic                 aclk     = 1'b0;
    logic                 aresetn  = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata  = '0;
    logic [0:0]           s_tuser  = OP_SYMBOL;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;
    logic                 m_tlast;

    // Mirror of the frame state held by the block.
    logic [BYTE_W-1:0]  byte_mirror [0:DEF_MAX_BYTES-1];
    int                 mirror_count = 0;
    logic [FLAGS_W-1:0] mirror_errors = '0;
    logic [BYTE_W-1:0]  mirror_crc = '0;
    logic [BYTE_W-1:0]  mirror_crc_prev = '0;

    frame_byte_t expected_bytes [$];
    logic [BYTE_W-1:0] frame_body [$];

    int items_sent     = 0;
    int frames_read    = 0;
    int frames_dropped = 0;
    int bytes_checked  = 0;
    int mismatches     = 0;
    int burst_left     = 0;
    bit sender_steady  = 1'b0;
    int rx_cycle       = 0;
    int idle_cycles    = 0;

    frame_byte_t got_byte;
    frame_byte_t want_byte;

    frame_symbol_deframer_crc_check_core #(
        .MAX_BYTES(DEF_MAX_BYTES),
        .MIN_BYTES(DEF_MIN_BYTES)
    ) DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    function automatic logic [BYTE_W-1:0] crc8_reflected(input logic [BYTE_W-1:0] crc,
                                                         input logic [BYTE_W-1:0] data);
        logic [BYTE_W-1:0] c;
        c = crc ^ data;
        for (int k = 0; k < BYTE_W; k++) begin
            if (c[0]) begin
                c = (c >> 1) ^ CRC_POLY;
            end else begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

    function automatic logic [SYMBOL_W-1:0] clean_symbol(input logic [BYTE_W-1:0] b);
        logic [SYMBOL_W-1:0] sym;
        sym = FRAME_MASK | STOP_MASK;
        for (int k = 0; k < BYTE_W; k++) begin
            sym[DATA_LSB + 2 * k] = b[BYTE_W - 1 - k];
        end
        sym[PARITY_BIT] = ^b;
        return sym;
    endfunction

    task automatic deframe_predict(input logic op, input logic [SYMBOL_W-1:0] sym);
        logic [BYTE_W-1:0]  value;
        logic [FLAGS_W-1:0] flags;
        int                 emit;
        frame_byte_t        item;
        items_sent++;
        if (op == OP_SYMBOL) begin
            if (mirror_count >= DEF_MAX_BYTES) begin
                return;
            end
            flags = '0;
            for (int k = 0; k < BYTE_W; k++) begin
                value[BYTE_W - 1 - k] = sym[DATA_LSB + 2 * k];
            end
            if (sym[SYMBOL_W-1]) begin
                flags = flags | ERR_START;
            end
            if (!sym[1]) begin
                flags = flags | ERR_STOP;
            end
            if ((sym & FRAME_MASK) != FRAME_MASK) begin
                flags = flags | ERR_FRAMING;
            end
            if (sym[PARITY_BIT] != ^value) begin
                flags = flags | ERR_PARITY;
            end
            byte_mirror[mirror_count] = value;
            mirror_count++;
            mirror_errors = mirror_errors | flags;
            mirror_crc_prev = mirror_crc;
            mirror_crc = crc8_reflected(mirror_crc, value);
            return;
        end
        if (mirror_count < DEF_MIN_BYTES) begin
            frames_dropped++;
        end else begin
            flags = mirror_errors;
            if (mirror_crc_prev != byte_mirror[mirror_count - 1]) begin
                flags = flags | ERR_CRC;
            end
            emit = (mirror_count - 1 > OUT_LIMIT) ? OUT_LIMIT : mirror_count - 1;
            for (int i = 0; i < emit; i++) begin
                item.value = byte_mirror[i];
                item.index = i[IDX_W-1:0];
                item.flags = flags;
                item.last  = (i + 1 == emit);
                expected_bytes.push_back(item);
            end
            frames_read++;
        end
        mirror_count = 0;
        mirror_errors = '0;
        mirror_crc = '0;
        mirror_crc_prev = '0;
    endtask

    task automatic send_item(input logic op, input logic [SYMBOL_W-1:0] sym);
        int gap;
        @(negedge aclk);
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {{(S_TDATA_W-SYMBOL_W){1'b0}}, sym};
        do begin
            @(posedge aclk);
        end while (s_tready !== 1'b1);
        deframe_predict(op, sym);
        if (sender_steady) begin
            return;
        end
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
            burst_left = $urandom_range(0, 20);
            repeat (gap) begin
                @(negedge aclk);
                s_tvalid <= 1'b0;
            end
        end
    endtask

    // Sends frame_body, its CRC byte, extra symbols (ignored once full) and
    // an end-of-packet transaction with a random symbol field.
    task automatic send_frame(input bit crc_ok, input int corrupt_at,
                              input logic [SYMBOL_W-1:0] flip, input int extra);
        logic [BYTE_W-1:0]   crc;
        logic [SYMBOL_W-1:0] sym;
        crc = '0;
        foreach (frame_body[i]) begin
            crc = crc8_reflected(crc, frame_body[i]);
        end
        if (!crc_ok) begin
            crc = crc ^ BYTE_W'($urandom_range(1, 255));
        end
        for (int i = 0; i <= frame_body.size(); i++) begin
            sym = clean_symbol((i == frame_body.size()) ? crc : frame_body[i]);
            if (i == corrupt_at) begin
                sym = sym ^ flip;
            end
            send_item(OP_SYMBOL, sym);
        end
        repeat (extra) begin
            send_item(OP_SYMBOL, SYMBOL_W'($urandom));
        end
        send_item(OP_EOP, SYMBOL_W'($urandom));
    endtask

    task automatic fill_body(input int n);
        frame_body.delete();
        repeat (n) begin
            frame_body.push_back(BYTE_W'($urandom));
        end
    endtask

    task automatic test_directed();
        send_item(OP_EOP, '0);
        send_item(OP_SYMBOL, clean_symbol(8'h00));
        send_item(OP_SYMBOL, clean_symbol(8'hFF));
        send_item(OP_SYMBOL, clean_symbol(8'h5A));
        send_item(OP_EOP, {SYMBOL_W{1'b1}});
        frame_body = '{8'h00, 8'hFF, 8'h80};
        send_frame(1'b1, -1, '0, 0);
        frame_body = '{8'h01, 8'h7F, 8'hA5, 8'h3C};
        send_item(OP_SYMBOL, clean_symbol(8'h01) ^ START_MASK);
        send_item(OP_SYMBOL, clean_symbol(8'h7F) ^ STOP_MASK);
        send_item(OP_SYMBOL, clean_symbol(8'hA5) ^ SYMBOL_W'(22'h00_0400));
        send_item(OP_SYMBOL, clean_symbol(8'h3C) ^ SYMBOL_W'(1 << PARITY_BIT));
        send_item(OP_SYMBOL, clean_symbol(8'h00));
        send_item(OP_EOP, '0);
        send_item(OP_SYMBOL, '0);
        send_item(OP_SYMBOL, {SYMBOL_W{1'b1}});
        send_item(OP_EOP, '0);
        frame_body = '{8'hC3, 8'h01, 8'h02};
        send_frame(1'b1, -1, '0, 0);
    endtask

    task automatic test_long_frames();
        sender_steady = 1'b1;
        fill_body(DEF_MAX_BYTES - 1);
        send_frame(1'b1, -1, '0, 0);
        sender_steady = 1'b0;
        fill_body(DEF_MAX_BYTES - 1);
        send_frame(1'b0, -1, '0, 6);
    endtask

    task automatic test_drain_pause();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (expected_bytes.size() != 0) begin
            @(posedge aclk);
        end
    endtask

    task automatic test_random_traffic();
        int  pick;
        int  len;
        bit  paused;
        paused = 1'b0;
        while (items_sent < ITEM_TARGET) begin
            pick = $urandom_range(0, 99);
            if (pick < 75) begin
                len = ($urandom_range(0, 9) == 0) ? $urandom_range(11, 32) : $urandom_range(4, 10);
                fill_body(len - 1);
                send_frame($urandom_range(0, 99) < 85,
                           ($urandom_range(0, 9) == 0) ? $urandom_range(0, len - 1) : -1,
                           SYMBOL_W'($urandom), 0);
            end else if (pick < 90) begin
                repeat ($urandom_range(0, 6)) begin
                    send_item(OP_SYMBOL, SYMBOL_W'($urandom));
                end
                send_item(OP_EOP, SYMBOL_W'($urandom));
            end else if (pick < 95) begin
                fill_body($urandom_range(0, 2));
                send_frame(1'b1, -1, '0, 0);
            end else begin
                fill_body(DEF_MAX_BYTES - 1);
                send_frame(1'b1, -1, '0, $urandom_range(1, 4));
            end
            if (!paused && items_sent >= ITEM_TARGET / 2) begin
                paused = 1'b1;
                test_drain_pause();
            end
        end
    endtask

    // Receiver stall pattern: steady, random, periodic and sparse phases.
    always @(negedge aclk) begin
        rx_cycle <= rx_cycle + 1;
        case ((rx_cycle / 200) % 4)
            0: begin
                m_tready <= 1'b1;
            end
            1: begin
                m_tready <= 1'($urandom_range(0, 1));
            end
            2: begin
                m_tready <= (rx_cycle % 7) < 3;
            end
            default: begin
                m_tready <= ($urandom_range(0, 7) == 0);
            end
        endcase
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            got_byte = {m_tdata[7:0], m_tdata[12:8], m_tdata[17:13], m_tlast};
            bytes_checked++;
            if (expected_bytes.size() == 0) begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT) begin
                    $display("Unexpected transaction: value %h index %0d flags %h last %b",
                             got_byte.value, got_byte.index, got_byte.flags, got_byte.last);
                end
            end else begin
                want_byte = expected_bytes.pop_front();
                if (got_byte.value !== want_byte.value || got_byte.index !== want_byte.index ||
                    got_byte.flags !== want_byte.flags || got_byte.last !== want_byte.last) begin
                    mismatches++;
                    if (mismatches <= REPORT_LIMIT) begin
                        $display("Mismatch: expected %h/%0d/%h/%b, got %h/%0d/%h/%b",
                                 want_byte.value, want_byte.index, want_byte.flags,
                                 want_byte.last, got_byte.value, got_byte.index,
                                 got_byte.flags, got_byte.last);
                    end
                end
            end
        end
    end

    initial begin
        while (idle_cycles < WATCHDOG_LIMIT) begin
            @(posedge aclk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
            end
        end
        $display("Watchdog expired with %0d bytes outstanding.", expected_bytes.size());
        $display("RESULT: ERROR");
        $finish;
    end

    initial begin
        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        test_directed();
        test_long_frames();
        test_random_traffic();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        test_drain_pause();
        repeat (16) @(posedge aclk);
        $display("Sent %0d transactions; %0d frames read out, %0d dropped as undersized.",
                 items_sent, frames_read, frames_dropped);
        $display("Checked %0d bytes across error, CRC, oversized and full-length frames.",
                 bytes_checked);
        if (mismatches == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("%0d mismatches found.", mismatches);
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
